// ===== src/two_end_positioner_fsm_macros.svh =====
// Assertion shorthands, all sampled on clk and disabled during reset.
`ifndef TWO_END_POSITIONER_FSM_MACROS_SVH
`define TWO_END_POSITIONER_FSM_MACROS_SVH

// Same-cycle implication.
`define TEPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TEPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tepf_pkg.sv =====
package tepf_pkg;

    localparam int POS_W   = 32;
    localparam int TIME_W  = 32;
    localparam int DWELL_W = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [POS_W-1:0] OPEN_END_RESET   = 32'sd0;
    localparam logic signed [POS_W-1:0] CLOSED_END_RESET = 32'sd4096;
    localparam logic [DWELL_W-1:0]      DWELL_RESET      = 16'd500;

    typedef enum logic [2:0] {
        ACT_BEGIN   = 3'd0,
        ACT_TICK    = 3'd1,
        ACT_OPEN    = 3'd2,
        ACT_CLOSE   = 3'd3,
        ACT_MOVE_TO = 3'd4,
        ACT_IDLE    = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_GO_CLOSE   = 3'd1,
        MODE_WAIT_CLOSE = 3'd2,
        MODE_GO_OPEN    = 3'd3,
        MODE_WAIT_OPEN  = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_END   = 2'd0,
        REG_CLOSED_END = 2'd1,
        REG_DWELL      = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0] open_end;
        logic signed [POS_W-1:0] closed_end;
        logic [DWELL_W-1:0]      dwell;
    } cfg_t;

    typedef struct packed {
        logic [2:0]              action;
        logic signed [POS_W-1:0] position;
        logic [TIME_W-1:0]       now_ms;
        logic signed [POS_W-1:0] goal;
    } item_t;

    typedef struct packed {
        mode_t                   mode;
        logic signed [POS_W-1:0] target;
        logic                    issue_move;
        logic                    save_request;
        logic signed [POS_W-1:0] position;
    } result_t;

endpackage

// ===== src/two_end_positioner_fsm.sv =====
// Channel   | handshake              | payload
// ----------+------------------------+----------------------------------------------
// request   | in_valid / in_stall    | action, position, now_ms, goal
// result    | out_valid / out_stall  | mode, target_out, issue_move, save_request,
//           |                        | position_out
// config    | cfg_we                 | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; an accepted request goes
// to the input register, then through the engine into the result register, whose
// contents stay on the outputs until taken.
// Controller state advances in the same cycle the request moves into the result register.
// rst_n is asynchronous, active low; clears control, state and config registers.
// in_stall rises only when both the input register and the result register are
// full and out_stall is high.
module two_end_positioner_fsm
    import tepf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [2:0]              action,
    input  logic signed [POS_W-1:0] position,
    input  logic [TIME_W-1:0]       now_ms,
    input  logic signed [POS_W-1:0] goal,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              mode,
    output logic signed [POS_W-1:0] target_out,
    output logic                    issue_move,
    output logic                    save_request,
    output logic signed [POS_W-1:0] position_out,

    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

`include "two_end_positioner_fsm_macros.svh"

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    tepf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // request moves into the result register when that register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    tepf_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= '{action: action, position: position, now_ms: now_ms, goal: goal};
        if (advance)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign mode         = res_reg.mode;
    assign target_out   = res_reg.target;
    assign issue_move   = res_reg.issue_move;
    assign save_request = res_reg.save_request;
    assign position_out = res_reg.position;

    `TEPF_ASSERT_NEXT(a_hold_pending, in_valid_reg && !advance && !in_take,
        in_valid_reg && $stable(item_reg), "pending request lost")
    `TEPF_ASSERT_NEXT(a_result_held, out_valid_reg && out_stall,
        out_valid_reg && $stable(res_reg), "stalled result changed")
    `TEPF_ASSERT_NOW(a_stall_only_full, in_stall, in_valid_reg && out_valid_reg,
        "stall with free space")

endmodule

// ===== src/tepf_cfg_regs.sv =====
module tepf_cfg_regs
    import tepf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_OPEN_END:   cfg_next.open_end   = $signed(cfg_data[POS_W-1:0]);
                REG_CLOSED_END: cfg_next.closed_end = $signed(cfg_data[POS_W-1:0]);
                REG_DWELL:      cfg_next.dwell      = cfg_data[DWELL_W-1:0];
                default:        cfg_next = cfg_reg;  // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_end   <= OPEN_END_RESET;
            cfg_reg.closed_end <= CLOSED_END_RESET;
            cfg_reg.dwell      <= DWELL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/tepf_engine.sv =====
module tepf_engine
    import tepf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

`include "two_end_positioner_fsm_macros.svh"

    mode_t                   mode_reg, mode_next;
    mode_t                   seen_reg, seen_next;
    logic                    issued_reg, issued_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic signed [POS_W-1:0] tgt_reg, tgt_next;
    logic [TIME_W-1:0]       wstart_reg, wstart_next;

    logic                    issue;
    logic                    save;
    logic signed [POS_W:0]   to_open;
    logic signed [POS_W:0]   to_close;
    logic [TIME_W-1:0]       elapsed;

    // distances for the nearer-end pick on begin
    assign to_open  = {item.position[POS_W-1], item.position}
                    - {cfg.open_end[POS_W-1], cfg.open_end};
    assign to_close = {cfg.closed_end[POS_W-1], cfg.closed_end}
                    - {item.position[POS_W-1], item.position};
    assign elapsed  = item.now_ms - wstart_reg;  // wraps mod 2^32

    always_comb
    begin
        mode_next   = mode_reg;
        seen_next   = seen_reg;
        issued_next = issued_reg;
        pos_next    = pos_reg;
        tgt_next    = tgt_reg;
        wstart_next = wstart_reg;
        issue       = 1'b0;
        save        = 1'b0;

        unique case (action_t'(item.action))
            ACT_BEGIN:
            begin
                pos_next = item.position;
                if (item.position >= cfg.closed_end)
                begin
                    tgt_next  = cfg.closed_end;
                    mode_next = (item.position == cfg.closed_end) ? MODE_IDLE : MODE_GO_CLOSE;
                end
                else if (item.position <= cfg.open_end)
                begin
                    tgt_next  = cfg.open_end;
                    mode_next = (item.position == cfg.open_end) ? MODE_IDLE : MODE_GO_OPEN;
                end
                else if (to_open < to_close)
                begin
                    tgt_next  = cfg.open_end;
                    mode_next = MODE_GO_OPEN;
                end
                else
                begin
                    tgt_next  = cfg.closed_end;
                    mode_next = MODE_GO_CLOSE;
                end
            end
            ACT_TICK:
            begin
                pos_next = item.position;
                if (mode_reg != seen_reg)
                begin
                    issued_next = 1'b0;
                    seen_next   = mode_reg;
                end
                if (mode_reg == MODE_GO_CLOSE || mode_reg == MODE_GO_OPEN)
                begin
                    if (!issued_next)
                    begin
                        issue       = 1'b1;
                        issued_next = 1'b1;
                    end
                    if (mode_reg == MODE_GO_CLOSE && item.position >= cfg.closed_end)
                    begin
                        mode_next   = MODE_WAIT_CLOSE;
                        wstart_next = item.now_ms;
                    end
                    else if (mode_reg == MODE_GO_OPEN && item.position <= cfg.open_end)
                    begin
                        mode_next   = MODE_WAIT_OPEN;
                        wstart_next = item.now_ms;
                    end
                end
                else if (mode_reg == MODE_WAIT_CLOSE || mode_reg == MODE_WAIT_OPEN)
                begin
                    if (elapsed >= {{(TIME_W-DWELL_W){1'b0}}, cfg.dwell})
                    begin
                        mode_next = MODE_IDLE;
                        save      = 1'b1;
                    end
                end
            end
            ACT_OPEN:
            begin
                tgt_next  = cfg.open_end;
                mode_next = MODE_GO_OPEN;
            end
            ACT_CLOSE:
            begin
                tgt_next  = cfg.closed_end;
                mode_next = MODE_GO_CLOSE;
            end
            ACT_MOVE_TO:
            begin
                // anything above the open end runs as a close move
                tgt_next  = item.goal;
                mode_next = (item.goal <= cfg.open_end) ? MODE_GO_OPEN : MODE_GO_CLOSE;
            end
            ACT_IDLE:
            begin
                mode_next = MODE_IDLE;
            end
            default:
            begin
                mode_next = mode_reg;  // unused action codes
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            seen_reg   <= MODE_IDLE;
            issued_reg <= 1'b0;
            pos_reg    <= '0;
            tgt_reg    <= '0;
            wstart_reg <= '0;
        end
        else if (en)
        begin
            mode_reg   <= mode_next;
            seen_reg   <= seen_next;
            issued_reg <= issued_next;
            pos_reg    <= pos_next;
            tgt_reg    <= tgt_next;
            wstart_reg <= wstart_next;
        end
    end

    assign res.mode         = mode_next;
    assign res.target       = tgt_next;
    assign res.issue_move   = issue;
    assign res.save_request = save;
    assign res.position     = pos_next;

    `TEPF_ASSERT_NOW(a_issue_save_excl, en, !(issue && save), "issue and save together")
    `TEPF_ASSERT_NEXT(a_issue_marks, en && issue, issued_reg && seen_reg == $past(mode_reg),
        "move issued but not recorded")
    `TEPF_ASSERT_NEXT(a_save_idle, en && save, mode_reg == MODE_IDLE, "save without idle")

endmodule

// ===== dv/two_end_positioner_fsm_tb.sv =====
module two_end_positioner_fsm_tb;
    import tepf_pkg::*;

    // Run bounds. Worst case per request is roughly a long send gap plus a long
    // receive stall plus the pipeline, plus one long hold-off; the limit is
    // several times that.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 120;
    localparam int HOLD_AT       = 250;   // result count that triggers the long hold-off
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;     // result passes the input and result registers after acceptance
    localparam int MAX_PRINTS    = 100;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // no register behind it
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;

    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [2:0]              action = '0;
    logic signed [POS_W-1:0] position = '0;
    logic [TIME_W-1:0]       now_ms = '0;
    logic signed [POS_W-1:0] goal = '0;

    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [2:0]              mode;
    logic signed [POS_W-1:0] target_out;
    logic                    issue_move;
    logic                    save_request;
    logic signed [POS_W-1:0] position_out;

    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;

    two_end_positioner_fsm DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .position     (position),
        .now_ms       (now_ms),
        .goal         (goal),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mode         (mode),
        .target_out   (target_out),
        .issue_move   (issue_move),
        .save_request (save_request),
        .position_out (position_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the controller: config and state
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] open_end_sh;
    logic signed [POS_W-1:0] closed_end_sh;
    logic [DWELL_W-1:0]      dwell_sh;

    mode_t                   mode_sh;
    mode_t                   seen_mode_sh;   // mode last observed by a tick
    logic                    move_sent_sh;   // move command already out for seen mode
    logic signed [POS_W-1:0] pos_sh;
    logic signed [POS_W-1:0] target_sh;
    logic [TIME_W-1:0]       dwell_from_sh;  // tick time at which an end was reached

    item_t   pending_reqs[$];     // requests not yet offered
    result_t expected_results[$]; // predicted results, oldest first
    item_t   offered_req;
    result_t want;

    int gap_left;
    int stall_left;
    int send_idle_pct;
    int recv_stall_pct;
    int results_seen;
    int error_count;
    int cycle_count;
    int phase_pushed;
    logic [TIME_W-1:0] clock_ms;  // stimulus millisecond clock

    // Advance the shadow controller by one request; returns what the block must show.
    function automatic result_t step_positioner(item_t req);
        result_t r;
        logic signed [POS_W-1:0] p;
        logic signed [POS_W-1:0] g;
        logic [TIME_W-1:0] elapsed;
        p = req.position;
        g = req.goal;
        r.issue_move = 1'b0;
        r.save_request = 1'b0;
        case (req.action)
            ACT_BEGIN:
            begin
                pos_sh = p;
                // closed end is checked first, which matters when the ends cross
                if (p >= closed_end_sh)
                begin
                    target_sh = closed_end_sh;
                    mode_sh = (p == closed_end_sh) ? MODE_IDLE : MODE_GO_CLOSE;
                end
                else if (p <= open_end_sh)
                begin
                    target_sh = open_end_sh;
                    mode_sh = (p == open_end_sh) ? MODE_IDLE : MODE_GO_OPEN;
                end
                else if ((longint'(p) - longint'(open_end_sh)) <
                         (longint'(closed_end_sh) - longint'(p)))
                begin
                    target_sh = open_end_sh;
                    mode_sh = MODE_GO_OPEN;
                end
                else
                begin
                    // tie goes to closed
                    target_sh = closed_end_sh;
                    mode_sh = MODE_GO_CLOSE;
                end
            end
            ACT_TICK:
            begin
                pos_sh = p;
                // a fresh move command only after a mode change has been seen here
                if (mode_sh != seen_mode_sh)
                begin
                    move_sent_sh = 1'b0;
                    seen_mode_sh = mode_sh;
                end
                if (mode_sh == MODE_GO_CLOSE || mode_sh == MODE_GO_OPEN)
                begin
                    if (!move_sent_sh)
                    begin
                        r.issue_move = 1'b1;
                        move_sent_sh = 1'b1;
                    end
                    // a move_to between the ends still only ends at closed
                    if (mode_sh == MODE_GO_CLOSE && p >= closed_end_sh)
                    begin
                        mode_sh = MODE_WAIT_CLOSE;
                        dwell_from_sh = req.now_ms;
                    end
                    else if (mode_sh == MODE_GO_OPEN && p <= open_end_sh)
                    begin
                        mode_sh = MODE_WAIT_OPEN;
                        dwell_from_sh = req.now_ms;
                    end
                end
                else if (mode_sh == MODE_WAIT_CLOSE || mode_sh == MODE_WAIT_OPEN)
                begin
                    elapsed = req.now_ms - dwell_from_sh;  // wraps mod 2^32
                    if (elapsed >= {16'd0, dwell_sh})
                    begin
                        mode_sh = MODE_IDLE;
                        r.save_request = 1'b1;
                    end
                end
            end
            ACT_OPEN:
            begin
                target_sh = open_end_sh;
                mode_sh = MODE_GO_OPEN;
            end
            ACT_CLOSE:
            begin
                target_sh = closed_end_sh;
                mode_sh = MODE_GO_CLOSE;
            end
            ACT_MOVE_TO:
            begin
                target_sh = g;
                mode_sh = (g <= open_end_sh) ? MODE_GO_OPEN : MODE_GO_CLOSE;
            end
            ACT_IDLE:
                mode_sh = MODE_IDLE;
            default:
                ;  // unused codes leave state alone
        endcase
        r.mode = mode_sh;
        r.target = target_sh;
        r.position = pos_sh;
        return r;
    endfunction

    // Mostly zero, sometimes a short gap, rarely a long one.
    function automatic int draw_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 8);
        return $urandom_range(3, 1);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at result %0d: %s expected %h got %h",
                     results_seen, what, exp_v, got_v);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued requests, holds payload while stalled
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(step_positioner(offered_req));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    offered_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    action   <= offered_req.action;
                    position <= offered_req.position;
                    now_ms   <= offered_req.now_ms;
                    goal     <= offered_req.goal;
                    gap_left = draw_gap(send_idle_pct);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result, drives random back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no request", '0, {29'd0, mode});
                else
                begin
                    want = expected_results.pop_front();
                    if (mode !== want.mode)
                        report_mismatch("mode", {29'd0, want.mode}, {29'd0, mode});
                    if (target_out !== want.target)
                        report_mismatch("target_out", want.target, target_out);
                    if (issue_move !== want.issue_move)
                        report_mismatch("issue_move", {31'd0, want.issue_move},
                                        {31'd0, issue_move});
                    if (save_request !== want.save_request)
                        report_mismatch("save_request", {31'd0, want.save_request},
                                        {31'd0, save_request});
                    if (position_out !== want.position)
                        report_mismatch("position_out", want.position, position_out);
                end
                results_seen++;
                // one long hold-off so the block fills up and stalls its input
                if (results_seen == HOLD_AT)
                    stall_left = HOLD_CYCLES;
            end
            if (stall_left == 0)
                stall_left = draw_gap(recv_stall_pct);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_req(logic [2:0] act, logic signed [POS_W-1:0] p,
                                     logic [TIME_W-1:0] t, logic signed [POS_W-1:0] g);
        item_t r;
        r.action = act;
        r.position = p;
        r.now_ms = t;
        r.goal = g;
        pending_reqs.push_back(r);
        if (act <= ACT_IDLE)
            phase_pushed++;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp32(longint v);
        if (v > POS_MAX)
            return POS_MAX[POS_W-1:0];
        if (v < POS_MIN)
            return POS_MIN[POS_W-1:0];
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] pick_between(longint lo, longint hi);
        longint unsigned span;
        longint unsigned off;
        span = hi - lo + 1;
        off = {$urandom, $urandom} % span;
        return POS_W'(lo + longint'(off));
    endfunction

    // A spot relative to the ends: on one, past one, or in between.
    function automatic logic signed [POS_W-1:0] pick_spot(longint lo, longint hi);
        case ($urandom_range(4))
            0: return open_end_sh;
            1: return closed_end_sh;
            2: return clamp32(hi + longint'($urandom_range(1000, 1)));
            3: return clamp32(lo - longint'($urandom_range(1000, 1)));
            default: return pick_between(lo, hi);
        endcase
    endfunction

    // Occasional junk request: any action, any payload.
    function automatic void add_noise();
        if ($urandom_range(9) == 0)
            push_req(3'($urandom_range(7)), $urandom, $urandom, $urandom);
    endfunction

    // One move: a starting request, a few ticks in transit, a tick at the end,
    // then ticks through the dwell until the save. Some are cut short.
    task automatic gen_episode();
        logic signed [POS_W-1:0] p;
        logic signed [POS_W-1:0] g;
        logic [TIME_W-1:0] reached_at;
        longint lo;
        longint hi;
        bit to_close;
        lo = (open_end_sh < closed_end_sh) ? open_end_sh : closed_end_sh;
        hi = (open_end_sh < closed_end_sh) ? closed_end_sh : open_end_sh;
        case ($urandom_range(5))
            0, 1:
            begin
                p = pick_spot(lo, hi);
                push_req(ACT_BEGIN, p, $urandom, $urandom);
                if (p >= closed_end_sh)
                    to_close = 1'b1;
                else if (p <= open_end_sh)
                    to_close = 1'b0;
                else
                    to_close = (longint'(p) - longint'(open_end_sh)) >=
                               (longint'(closed_end_sh) - longint'(p));
            end
            2:
            begin
                push_req(ACT_CLOSE, $urandom, $urandom, $urandom);
                to_close = 1'b1;
            end
            3:
            begin
                push_req(ACT_OPEN, $urandom, $urandom, $urandom);
                to_close = 1'b0;
            end
            default:
            begin
                g = pick_spot(lo, hi);
                push_req(ACT_MOVE_TO, $urandom, $urandom, g);
                to_close = !(g <= open_end_sh);
            end
        endcase
        add_noise();

        repeat ($urandom_range(5))
        begin
            clock_ms += $urandom_range(50);
            push_req(ACT_TICK, pick_between(lo, hi), clock_ms, $urandom);
            add_noise();
        end
        if ($urandom_range(7) == 0)
            return;  // broken move, never reaches the end

        clock_ms += $urandom_range(50);
        if (to_close)
            p = $urandom_range(1) ? closed_end_sh
                : clamp32(longint'(closed_end_sh) + longint'($urandom_range(100, 1)));
        else
            p = $urandom_range(1) ? open_end_sh
                : clamp32(longint'(open_end_sh) - longint'($urandom_range(100, 1)));
        push_req(ACT_TICK, p, clock_ms, $urandom);
        reached_at = clock_ms;
        add_noise();

        repeat ($urandom_range(2))
        begin
            clock_ms += $urandom_range(dwell_sh / 3);
            push_req(ACT_TICK, p, clock_ms, $urandom);
        end
        // just short of the dwell, then at or past it
        if (dwell_sh > 0 && $urandom_range(1))
            push_req(ACT_TICK, p, reached_at + dwell_sh - 1, $urandom);
        clock_ms = reached_at + dwell_sh + $urandom_range(2);
        push_req(ACT_TICK, p, clock_ms, $urandom);
        add_noise();
    endtask

    // Config is only touched with the block empty.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OPEN_END:   open_end_sh = data;
            REG_CLOSED_END: closed_end_sh = data;
            REG_DWELL:      dwell_sh = data[DWELL_W-1:0];
            default:        ;  // out-of-range index is dropped
        endcase
    endtask

    // Wait until every request is in and every result is out, then let the pipe run dry.
    task automatic wait_settled();
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic signed [POS_W-1:0] op, logic signed [POS_W-1:0] cl,
                             logic [DWELL_W-1:0] dw, int send_pct, int recv_pct,
                             logic [TIME_W-1:0] t0);
        write_reg(REG_OPEN_END, op);
        write_reg(REG_CLOSED_END, cl);
        write_reg(REG_DWELL, {16'($urandom), dw});  // upper bits must be ignored
        write_reg(REG_SPARE, $urandom);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        clock_ms = t0;
        phase_pushed = 0;
        while (phase_pushed < PHASE_ITEMS)
            gen_episode();
        wait_settled();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        open_end_sh   = OPEN_END_RESET;
        closed_end_sh = CLOSED_END_RESET;
        dwell_sh      = DWELL_RESET;
        mode_sh       = MODE_IDLE;
        seen_mode_sh  = MODE_IDLE;
        move_sent_sh  = 1'b0;
        pos_sh        = '0;
        target_sh     = '0;
        dwell_from_sh = '0;
        error_count   = 0;
        results_seen  = 0;
        cycle_count   = 0;
        send_idle_pct = 25;
        recv_stall_pct = 25;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset config: open 0, closed 4096, dwell 500.
        push_req(ACT_BEGIN, 32'sd4096, '0, '0);          // exactly closed -> idle
        push_req(ACT_BEGIN, 32'sd5000, '0, '0);          // past closed -> go close
        push_req(ACT_TICK, 32'sd100, 32'd1000, '0);      // first tick issues move
        push_req(ACT_TICK, 32'sd4096, 32'd2000, '0);     // reached closed
        push_req(ACT_TICK, 32'sd4096, 32'd2499, '0);     // one short of dwell
        push_req(ACT_TICK, 32'sd4096, 32'd2500, '0);     // dwell done -> idle, save
        push_req(ACT_BEGIN, 32'sd0, '0, '0);             // exactly open -> idle
        push_req(ACT_BEGIN, -32'sd7, '0, '0);            // past open -> go open
        push_req(ACT_TICK, -32'sd7, 32'hFFFF_FF00, '0);  // issue and reach open
        push_req(ACT_TICK, -32'sd7, 32'h0000_00F3, '0);  // wrapped, 499 elapsed
        push_req(ACT_TICK, -32'sd7, 32'h0000_00F4, '0);  // wrapped, 500 elapsed
        push_req(ACT_BEGIN, 32'sd2048, '0, '0);          // tie -> closed
        push_req(ACT_BEGIN, 32'sd2047, '0, '0);          // nearer open
        push_req(ACT_OPEN, '0, '0, '0);
        push_req(ACT_CLOSE, '0, '0, '0);
        push_req(ACT_MOVE_TO, '0, '0, 32'sd1000);        // between ends -> go close
        push_req(ACT_TICK, 32'sd1000, 32'd10, '0);       // issues, does not finish
        push_req(ACT_CLOSE, '0, '0, '0);                 // same mode again
        push_req(ACT_TICK, 32'sd1000, 32'd20, '0);       // no reissue
        push_req(ACT_TICK, 32'sd4096, 32'd30, '0);       // only closed ends it
        push_req(ACT_MOVE_TO, '0, '0, 32'sh8000_0000);   // most negative goal
        push_req(ACT_MOVE_TO, '0, '0, 32'sh7FFF_FFFF);   // most positive goal
        push_req(ACT_IDLE, '0, '0, '0);
        push_req(ACT_SPARE_A, 32'shFFFF_FFFF, 32'hFFFF_FFFF, 32'shFFFF_FFFF);
        push_req(ACT_SPARE_B, '0, '0, '0);
        push_req(ACT_BEGIN, 32'sh7FFF_FFFF, '0, '0);
        push_req(ACT_BEGIN, 32'sh8000_0000, '0, '0);
        push_req(ACT_TICK, 32'sh8000_0000, 32'hFFFF_FFFF, '0);
        wait_settled();

        // Random phases across settings, extremes included.
        run_phase(-32'sd1000, 32'sd1000, 16'd0, 20, 20, $urandom);
        // widest ends, longest dwell, clock near wrap; no idling, hold-off lands here
        run_phase(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 0, 0, 32'hFFFF_0000);
        run_phase(32'sd5000, -32'sd5000, 16'd7, 30, 30, $urandom);   // crossed ends
        run_phase(32'sd123, 32'sd123, 16'd1, 10, 40, $urandom);      // ends coincide
        run_phase(pick_between(-100000, 100000), '0, 16'($urandom_range(2000)),
                  40, 10, $urandom);
        write_reg(REG_CLOSED_END, clamp32(longint'(open_end_sh) +
                                          longint'($urandom_range(200000, 1))));
        phase_pushed = 0;
        while (phase_pushed < PHASE_ITEMS)
            gen_episode();
        wait_settled();
        run_phase(OPEN_END_RESET, CLOSED_END_RESET, DWELL_RESET, 20, 20, 32'hFFFF_FE00);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
